/* rtl/core/wavhdr_pkg.sv */
// ----------------------------------------------------------------------------
// wavhdr_pkg: shared types and constants for the WAV header chunk parser
// Phase and status codes, chunk tags, and the packed result item.
// ----------------------------------------------------------------------------
`default_nettype none

package wavhdr_pkg;

  typedef enum logic [2:0] {
    PH_RIFF = 3'd0,
    PH_HDR  = 3'd1,
    PH_FMT  = 3'd2,
    PH_SKIP = 3'd3,
    PH_DONE = 3'd4
  } phase_e;

  typedef enum logic [2:0] {
    ST_ACCEPTED         = 3'd0,
    ST_UNSUPPORTED      = 3'd1,
    ST_BAD_TAG          = 3'd2,
    ST_TRUNCATED        = 3'd3,
    ST_FMT_SHORT        = 3'd4,
    ST_DATA_BEFORE_FMT  = 3'd5
  } status_e;

  localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
  localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
  localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
  localparam logic [31:0] TAG_DATA = 32'h6461_7461;

  localparam logic [31:0] FMT_MIN        = 32'd16;
  localparam logic [3:0]  FMT_LAST_IDX   = 4'd15;
  localparam logic [3:0]  FMT_BITS_AT    = 4'd14;
  localparam logic [3:0]  RIFF_TAG_IDX   = 4'd3;
  localparam logic [3:0]  WAVE_TAG_IDX   = 4'd11;
  localparam logic [3:0]  HDR_LAST_IDX   = 4'd7;
  localparam logic [31:0] REQ_RATE_RESET = 32'd16000;
  localparam logic [15:0] FMT_PCM        = 16'd1;
  localparam logic [15:0] MONO           = 16'd1;
  localparam logic [15:0] BITS_16        = 16'd16;

  typedef struct packed {
    status_e     status;
    logic [15:0] fmt_code;
    logic [15:0] channel_count;
    logic [31:0] rate_hz;
    logic [15:0] sample_bits;
    logic [31:0] payload_offset;
    logic [31:0] payload_bytes;
  } result_t;

endpackage

`default_nettype wire

/* rtl/core/wav_header_chunk_parser_top.sv */
// ----------------------------------------------------------------------------
// wav_header_chunk_parser_top: RIFF/WAVE header and chunk walker
// Checks the file header, walks chunks, captures the fmt fields and reports
// one result when the data chunk header completes, a check fails or the file ends early.
//   Input channel (in_valid_i / in_stall_o) carries one file byte per item,
//   with first_byte_i marking byte 0 of a new file and last_byte_i the end.
//   Output channel (out_valid_o / out_stall_i) carries at most one result
//   item per file: status, fmt fields, data offset and data size.
//   cfg_we_i / cfg_wdata_i set the required sample rate; write it only while
//   the parser is idle.
//   Throughput: one byte per cycle while in_stall_o is low. The per-byte state
//   update is one pass of logic from the parse registers back into themselves.
//   A result is registered into the output register, or into the skid register
//   when the output register still holds a result that has not been taken.
//   Stall: the output register is backed by a one-entry skid register, so
//   bytes keep flowing while a result waits; in_stall_o rises only when both
//   hold a result.
//   Reset: parser goes to the RIFF header phase, output is empty, the
//   required rate returns to 16000.
// ----------------------------------------------------------------------------
`default_nettype none

module wav_header_chunk_parser_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [31:0] cfg_wdata_i,
  input  wire logic        in_valid_i,
  output      logic        in_stall_o,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        first_byte_i,
  input  wire logic        last_byte_i,
  output      logic        out_valid_o,
  input  wire logic        out_stall_i,
  output      logic [2:0]  status_o,
  output      logic [15:0] fmt_code_o,
  output      logic [15:0] channel_count_o,
  output      logic [31:0] rate_hz_o,
  output      logic [15:0] sample_bits_o,
  output      logic [31:0] payload_offset_o,
  output      logic [31:0] payload_bytes_o
);

  wavhdr_pkg::phase_e  phase_q, phase_d;
  logic [31:0]         pos_q, pos_d;
  logic [3:0]          idx_q, idx_d;
  logic [31:0]         tag_q, tag_d;
  logic [31:0]         size_q, size_d;
  logic [32:0]         skip_q, skip_d;
  logic [63:0]         ff_q, ff_d;
  logic [15:0]         bits_q, bits_d;
  logic                saw_q, saw_d;
  logic [31:0]         req_rate_q;

  logic                in_fire;
  logic                emit;
  wavhdr_pkg::status_e st;
  logic [31:0]         res_off;
  logic [31:0]         res_size;
  logic                do_skip;
  logic [32:0]         skip_len;
  logic                fmt_ok;
  wavhdr_pkg::result_t res;

  wavhdr_pkg::result_t out_q, skid_q;
  logic                out_valid_q, skid_valid_q;
  logic                out_take;

  assign in_stall_o = skid_valid_q;
  assign in_fire    = in_valid_i & ~skid_valid_q;
  assign out_take   = out_valid_q & ~out_stall_i;

  assign fmt_ok = (ff_q[15:0] == wavhdr_pkg::FMT_PCM) && (ff_q[31:16] == wavhdr_pkg::MONO) &&
                  (bits_q == wavhdr_pkg::BITS_16) && (ff_q[63:32] == req_rate_q);

  // next parse state
  always_comb begin
    phase_d  = phase_q;
    pos_d    = pos_q;
    idx_d    = idx_q;
    tag_d    = tag_q;
    size_d   = size_q;
    skip_d   = skip_q;
    ff_d     = ff_q;
    bits_d   = bits_q;
    saw_d    = saw_q;
    emit     = 1'b0;
    st       = wavhdr_pkg::ST_ACCEPTED;
    res_off  = '0;
    res_size = '0;
    do_skip  = 1'b0;
    skip_len = '0;
    if (in_fire) begin
      if (first_byte_i) begin
        phase_d = wavhdr_pkg::PH_RIFF;
        pos_d   = '0;
        idx_d   = '0;
        tag_d   = '0;
        size_d  = '0;
        skip_d  = '0;
        ff_d    = '0;
        bits_d  = '0;
        saw_d   = 1'b0;
      end
      if (phase_d != wavhdr_pkg::PH_DONE) begin
        pos_d = pos_d + 32'd1;
        case (phase_d)
          wavhdr_pkg::PH_RIFF: begin
            tag_d = {tag_d[23:0], data_byte_i};
            if (idx_d == wavhdr_pkg::RIFF_TAG_IDX && tag_d != wavhdr_pkg::TAG_RIFF) begin
              emit = 1'b1;
              st   = wavhdr_pkg::ST_BAD_TAG;
            end else if (idx_d == wavhdr_pkg::WAVE_TAG_IDX) begin
              if (tag_d != wavhdr_pkg::TAG_WAVE) begin
                emit = 1'b1;
                st   = wavhdr_pkg::ST_BAD_TAG;
              end else begin
                idx_d   = '0;
                tag_d   = '0;
                phase_d = wavhdr_pkg::PH_HDR;
              end
            end else begin
              idx_d = idx_d + 4'd1;
            end
          end
          wavhdr_pkg::PH_HDR: begin
            if (idx_d < 4'd4) begin
              tag_d = {tag_d[23:0], data_byte_i};
            end else begin
              size_d[{idx_d[1:0], 3'b000} +: 8] = data_byte_i;
            end
            if (idx_d < wavhdr_pkg::HDR_LAST_IDX) begin
              idx_d = idx_d + 4'd1;
            end else if (tag_d == wavhdr_pkg::TAG_DATA) begin
              emit     = 1'b1;
              res_off  = pos_d;
              res_size = size_d;
              if (!saw_d) begin
                st = wavhdr_pkg::ST_DATA_BEFORE_FMT;
              end else if (fmt_ok) begin
                st = wavhdr_pkg::ST_ACCEPTED;
              end else begin
                st = wavhdr_pkg::ST_UNSUPPORTED;
              end
            end else if (tag_d == wavhdr_pkg::TAG_FMT) begin
              if (size_d < wavhdr_pkg::FMT_MIN) begin
                emit = 1'b1;
                st   = wavhdr_pkg::ST_FMT_SHORT;
              end else begin
                idx_d   = '0;
                ff_d    = '0;
                bits_d  = '0;
                saw_d   = 1'b0;
                phase_d = wavhdr_pkg::PH_FMT;
              end
            end else begin
              do_skip  = 1'b1;
              skip_len = {1'b0, size_d} + {32'd0, size_d[0]};
            end
          end
          wavhdr_pkg::PH_FMT: begin
            if (idx_d < 4'd8) begin
              ff_d[{idx_d[2:0], 3'b000} +: 8] = data_byte_i;
            end else if (idx_d >= wavhdr_pkg::FMT_BITS_AT) begin
              bits_d[{idx_d[0], 3'b000} +: 8] = data_byte_i;
            end
            if (idx_d == wavhdr_pkg::FMT_LAST_IDX) begin
              saw_d    = 1'b1;
              do_skip  = 1'b1;
              skip_len = {1'b0, size_d - wavhdr_pkg::FMT_MIN} + {32'd0, size_d[0]};
            end else begin
              idx_d = idx_d + 4'd1;
            end
          end
          wavhdr_pkg::PH_SKIP: begin
            if (skip_d != '0) begin
              skip_d = skip_d - 33'd1;
            end
            if (skip_d == '0) begin
              do_skip = 1'b1;
            end
          end
          default: begin
          end
        endcase
        if (do_skip) begin
          idx_d   = '0;
          tag_d   = '0;
          size_d  = '0;
          skip_d  = skip_len;
          phase_d = (skip_len == '0) ? wavhdr_pkg::PH_HDR : wavhdr_pkg::PH_SKIP;
        end
        if (!emit && last_byte_i) begin
          emit     = 1'b1;
          st       = wavhdr_pkg::ST_TRUNCATED;
          res_off  = '0;
          res_size = '0;
        end
        if (emit) begin
          phase_d = wavhdr_pkg::PH_DONE;
        end
      end
    end
  end

  // result item
  always_comb begin
    res.status         = st;
    res.fmt_code       = saw_d ? ff_d[15:0]  : 16'd0;
    res.channel_count  = saw_d ? ff_d[31:16] : 16'd0;
    res.rate_hz        = saw_d ? ff_d[63:32] : 32'd0;
    res.sample_bits    = saw_d ? bits_d      : 16'd0;
    res.payload_offset = res_off;
    res.payload_bytes  = res_size;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= wavhdr_pkg::PH_RIFF;
      pos_q      <= '0;
      idx_q      <= '0;
      tag_q      <= '0;
      size_q     <= '0;
      skip_q     <= '0;
      ff_q       <= '0;
      bits_q     <= '0;
      saw_q      <= 1'b0;
      req_rate_q <= wavhdr_pkg::REQ_RATE_RESET;
    end else begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      idx_q   <= idx_d;
      tag_q   <= tag_d;
      size_q  <= size_d;
      skip_q  <= skip_d;
      ff_q    <= ff_d;
      bits_q  <= bits_d;
      saw_q   <= saw_d;
      if (cfg_we_i) begin
        req_rate_q <= cfg_wdata_i;
      end
    end
  end

  // output register with skid entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_take) begin
      if (skid_valid_q) begin
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= emit;
      end
    end else if (out_valid_q) begin
      if (emit) begin
        skid_valid_q <= 1'b1;
      end
    end else begin
      out_valid_q <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_take) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
      end else if (emit) begin
        out_q <= res;
      end
    end else if (out_valid_q) begin
      if (emit) begin
        skid_q <= res;
      end
    end else if (emit) begin
      out_q <= res;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = out_q.status;
  assign fmt_code_o       = out_q.fmt_code;
  assign channel_count_o  = out_q.channel_count;
  assign rate_hz_o        = out_q.rate_hz;
  assign sample_bits_o    = out_q.sample_bits;
  assign payload_offset_o = out_q.payload_offset;
  assign payload_bytes_o  = out_q.payload_bytes;

endmodule

`default_nettype wire

/* rtl/core/wavhdr_checker.sv */
// ----------------------------------------------------------------------------
// wavhdr_checker: port-level checks for the WAV header chunk parser
// Watches the top-level ports and is bound to every instance of it.
// ----------------------------------------------------------------------------
`default_nettype none

module wavhdr_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_stall_i,
  input wire logic        out_valid_i,
  input wire logic        out_stall_i,
  input wire logic [2:0]  status_i,
  input wire logic [15:0] fmt_code_i,
  input wire logic [15:0] channel_count_i,
  input wire logic [15:0] sample_bits_i,
  input wire logic [31:0] payload_offset_i,
  input wire logic [31:0] payload_bytes_i
);

  // held result stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_stall_i |=> out_valid_i && $stable(status_i) &&
    $stable(payload_offset_i) && $stable(payload_bytes_i))
    else $error("stalled result changed");

  // skid entry is only used behind a full output register
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_i |-> out_valid_i)
    else $error("input stalled with empty output");

  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> status_i <= 3'(wavhdr_pkg::ST_DATA_BEFORE_FMT))
    else $error("status out of range");

  // offset and size only come with a data chunk header
  a_no_data_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (status_i == 3'(wavhdr_pkg::ST_BAD_TAG) ||
    status_i == 3'(wavhdr_pkg::ST_TRUNCATED) ||
    status_i == 3'(wavhdr_pkg::ST_FMT_SHORT)) |->
    payload_offset_i == 32'd0 && payload_bytes_i == 32'd0)
    else $error("offset or size without data chunk");

  a_accept_fmt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i == 3'(wavhdr_pkg::ST_ACCEPTED) |->
    fmt_code_i == wavhdr_pkg::FMT_PCM && channel_count_i == wavhdr_pkg::MONO &&
    sample_bits_i == wavhdr_pkg::BITS_16)
    else $error("accepted file is not PCM mono 16-bit");

endmodule

bind wav_header_chunk_parser_top wavhdr_checker u_wavhdr_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_stall_i       (in_stall_o),
  .out_valid_i      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .status_i         (status_o),
  .fmt_code_i       (fmt_code_o),
  .channel_count_i  (channel_count_o),
  .sample_bits_i    (sample_bits_o),
  .payload_offset_i (payload_offset_o),
  .payload_bytes_i  (payload_bytes_o)
);

`default_nettype wire
